[hw/rtl/partitioned_send_buffer_allocator_assert.svh]
// Assertion macros shared by the allocator RTL.
`ifndef PARTITIONED_SEND_BUFFER_ALLOCATOR_ASSERT_SVH
`define PARTITIONED_SEND_BUFFER_ALLOCATOR_ASSERT_SVH

`ifndef ASSERT_OFF

`define PSBA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

`define PSBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`else

`define PSBA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define PSBA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/psba_pkg.sv]
package psba_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_SCAN,
        S_DONE
    } t_state;

    typedef logic [7:0] t_count;
    typedef logic [7:0] t_tag;

    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_CANCEL  = 2'd2;

    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_NO_BUFFER = 2'd1;
    localparam logic [1:0] STATUS_WAS_FREE  = 2'd2;

    localparam logic [2:0] CFG_SPLIT_INDEX     = 3'd0;
    localparam logic [2:0] CFG_NODE_COUNT      = 3'd1;
    localparam logic [2:0] CFG_HOST_CODE       = 3'd2;
    localparam logic [2:0] CFG_BROADCAST_CODE  = 3'd3;
    localparam logic [2:0] CFG_STALL_THRESHOLD = 3'd4;

    localparam logic [5:0]  RST_SPLIT_INDEX     = 6'd16;
    localparam logic [7:0]  RST_NODE_COUNT      = 8'd16;
    localparam logic [7:0]  RST_HOST_CODE       = 8'd255;
    localparam logic [7:0]  RST_BROADCAST_CODE  = 8'd254;
    localparam logic [15:0] RST_STALL_THRESHOLD = 16'd10000;

endpackage

[hw/rtl/partitioned_send_buffer_allocator.sv]
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    kind, dest, is_system, is_anti, buffer_index
// output    out        o_out_valid / i_out_stall  status, granted_index, count_after,
//                                                 is_priority, stall_flag
// config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// An item passes through accept (memory reads issued), search/modify/write, and result.
// A low-partition allocate that finds no free buffer may walk the destination tag
// memory through its single read port, one entry a cycle, over entries 1 to split-1,
// where split is split_index capped at NUM_BUFFERS.
// Reset needs no clearing pass: free bits and tag valid bits are flip-flops.
// While the output register holds a stalled item, the next result waits in the done state.
`include "partitioned_send_buffer_allocator_assert.svh"

module partitioned_send_buffer_allocator import psba_pkg::*; #(
    parameter int NUM_BUFFERS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_dest,
    input  logic        i_is_system,
    input  logic        i_is_anti,
    input  logic [4:0]  i_buffer_index,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [4:0]  o_granted_index,
    output logic [7:0]  o_count_after,
    output logic        o_is_priority,
    output logic        o_stall_flag,

    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int IW = $clog2(NUM_BUFFERS);
    localparam int CW = $clog2(NUM_BUFFERS + 1);

    // configuration
    logic [5:0]  r_split;
    t_count      r_nodes;
    t_tag        r_host;
    t_tag        r_bcast;
    logic [15:0] r_thresh;
    logic [CW-1:0] w_split;

    // control
    t_state      r_st, n_st;
    logic [1:0]  r_kind;
    t_tag        r_dest;
    logic        r_prio;
    logic [4:0]  r_idx;
    logic        r_in_range;
    logic [15:0] r_fail;
    logic [NUM_BUFFERS-1:0] r_free;
    logic [NUM_BUFFERS-1:0] r_tag_ok;
    logic [IW-1:0] r_scan_addr;
    t_tag        r_tag0;

    // memories
    t_count      r_cnt_mem [NUM_BUFFERS];
    t_tag        r_tag_mem [NUM_BUFFERS];
    t_count      r_cnt_rd;
    t_tag        r_tag_rd;
    logic        r_tag_rd_ok;

    logic [IW-1:0] w_cnt_raddr;
    logic [IW-1:0] w_tag_raddr;
    logic          w_cnt_we;
    logic [IW-1:0] w_cnt_waddr;
    t_count        w_cnt_wdata;
    logic          w_tag_we;

    // datapath
    logic          w_in_acc;
    logic          w_out_busy;
    logic [NUM_BUFFERS-1:0] w_cand;
    logic          w_found;
    logic [IW-1:0] w_pick;
    logic [IW-1:0] w_idx_r;
    t_tag          w_tag_val;
    t_count        w_grant_cnt;
    t_count        w_rel_cnt;
    logic [16:0]   w_fail_inc;
    logic          w_stall_hit;
    logic          w_last_scan;

    // actions
    logic          w_finish;
    logic          w_grant;
    logic          w_fail;
    logic          w_rel_wr;
    logic          w_cancel;
    logic          w_scan_start;
    logic          w_scan_next;
    logic [IW-1:0] w_grant_idx;

    logic [1:0]    w_res_status;
    logic [4:0]    w_res_idx;
    t_count        w_res_cnt;
    logic          w_res_prio;
    logic          w_res_stall;

    logic [1:0]    r_res_status;
    logic [4:0]    r_res_idx;
    t_count        r_res_cnt;
    logic          r_res_prio;
    logic          r_res_stall;

    logic          r_out_valid;
    logic [1:0]    r_out_status;
    logic [4:0]    r_out_idx;
    t_count        r_out_cnt;
    logic          r_out_prio;
    logic          r_out_stall;

    assign w_split = (32'(r_split) > NUM_BUFFERS) ? CW'(NUM_BUFFERS) : CW'(r_split);

    assign w_in_acc   = i_in_valid && (r_st == S_IDLE);
    assign o_in_stall = (r_st != S_IDLE);
    assign w_out_busy = r_out_valid && i_out_stall;

    assign w_idx_r     = IW'(r_idx);
    assign w_cnt_raddr = IW'(i_buffer_index);
    assign w_tag_val   = r_tag_rd_ok ? r_tag_rd : '0;
    assign w_rel_cnt   = r_cnt_rd - 8'd1;
    assign w_fail_inc  = {1'b0, r_fail} + 17'd1;
    assign w_stall_hit = w_fail_inc > {1'b0, r_thresh};
    assign w_last_scan = (CW'(r_scan_addr) == (w_split - CW'(1)));

    assign w_grant_cnt = ((r_dest != r_host) && (r_dest == r_bcast))
                       ? ((r_nodes == 8'd0) ? 8'd0 : r_nodes - 8'd1)
                       : 8'd1;

    // Lowest free buffer inside the partition that the request belongs to.
    always_comb begin
        w_pick = '0;
        for (int i = 0; i < NUM_BUFFERS; i++) begin
            w_cand[i] = r_free[i] && (r_prio ? (i >= int'(w_split)) : (i < int'(w_split)));
        end
        for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
            if (w_cand[i]) begin
                w_pick = IW'(i);
            end
        end
    end
    assign w_found = |w_cand;

    // Tag read address: tag 0 at accept, then the walk over the low partition.
    always_comb begin
        case (r_st)
            S_FIND:  w_tag_raddr = IW'(1);
            S_SCAN:  w_tag_raddr = r_scan_addr + IW'(1);
            default: w_tag_raddr = '0;
        endcase
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_st = S_FIND;
                end
            end
            S_FIND: begin
                n_st = w_scan_start ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                if (w_finish) begin
                    n_st = S_DONE;
                end
            end
            S_DONE: begin
                if (!w_out_busy) begin
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_comb begin
        w_finish     = 1'b0;
        w_grant      = 1'b0;
        w_fail       = 1'b0;
        w_rel_wr     = 1'b0;
        w_cancel     = 1'b0;
        w_scan_start = 1'b0;
        w_scan_next  = 1'b0;
        w_grant_idx  = w_pick;
        case (r_st)
            S_FIND: begin
                case (r_kind)
                    KIND_ALLOC: begin
                        if (w_found) begin
                            w_grant = 1'b1;
                        end else if (!r_prio && (w_tag_val != r_dest)
                                     && r_free[NUM_BUFFERS-1]) begin
                            // Fallback to the last buffer needs all low tags equal.
                            if (w_split <= CW'(1)) begin
                                w_grant     = 1'b1;
                                w_grant_idx = IW'(NUM_BUFFERS - 1);
                            end else begin
                                w_scan_start = 1'b1;
                            end
                        end else begin
                            w_fail = 1'b1;
                        end
                    end
                    KIND_RELEASE: begin
                        w_finish = 1'b1;
                        w_rel_wr = r_in_range && !r_free[w_idx_r];
                    end
                    KIND_CANCEL: begin
                        w_finish = 1'b1;
                        w_cancel = r_in_range;
                    end
                    default: w_finish = 1'b1;
                endcase
            end
            S_SCAN: begin
                if (w_tag_val != r_tag0) begin
                    w_fail = 1'b1;
                end else if (w_last_scan) begin
                    w_grant     = 1'b1;
                    w_grant_idx = IW'(NUM_BUFFERS - 1);
                end else begin
                    w_scan_next = 1'b1;
                end
            end
            default: ;
        endcase
        if (w_grant || w_fail) begin
            w_finish = 1'b1;
        end
    end

    always_comb begin
        w_res_status = STATUS_DONE;
        w_res_idx    = '0;
        w_res_cnt    = '0;
        w_res_prio   = 1'b0;
        w_res_stall  = 1'b0;
        case (r_kind)
            KIND_ALLOC: begin
                w_res_prio = r_prio;
                if (w_grant) begin
                    w_res_idx = 5'(w_grant_idx);
                    w_res_cnt = w_grant_cnt;
                end else begin
                    w_res_status = STATUS_NO_BUFFER;
                    w_res_stall  = w_stall_hit;
                end
            end
            KIND_RELEASE: begin
                w_res_idx = r_idx;
                if (w_rel_wr) begin
                    w_res_cnt = w_rel_cnt;
                end else begin
                    w_res_status = STATUS_WAS_FREE;
                end
            end
            KIND_CANCEL: begin
                w_res_idx = r_idx;
                if (!r_in_range) begin
                    w_res_status = STATUS_WAS_FREE;
                end
            end
            default: ;
        endcase
    end

    assign w_cnt_we    = w_grant || w_rel_wr;
    assign w_cnt_waddr = w_grant ? w_grant_idx : w_idx_r;
    assign w_cnt_wdata = w_grant ? w_grant_cnt : w_rel_cnt;
    assign w_tag_we    = w_grant;

    // The state machine keeps every write ahead of the next item's reads, with the done
    // state between them, so no forwarding path is needed.
    always_ff @(posedge i_clk) begin
        if (w_cnt_we) begin
            r_cnt_mem[w_cnt_waddr] <= w_cnt_wdata;
        end
        if (w_tag_we) begin
            r_tag_mem[w_grant_idx] <= r_dest;
        end
        r_cnt_rd    <= r_cnt_mem[w_cnt_raddr];
        r_tag_rd    <= r_tag_mem[w_tag_raddr];
        r_tag_rd_ok <= r_tag_ok[w_tag_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split  <= RST_SPLIT_INDEX;
            r_nodes  <= RST_NODE_COUNT;
            r_host   <= RST_HOST_CODE;
            r_bcast  <= RST_BROADCAST_CODE;
            r_thresh <= RST_STALL_THRESHOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SPLIT_INDEX:     r_split  <= i_cfg_data[5:0];
                CFG_NODE_COUNT:      r_nodes  <= i_cfg_data[7:0];
                CFG_HOST_CODE:       r_host   <= i_cfg_data[7:0];
                CFG_BROADCAST_CODE:  r_bcast  <= i_cfg_data[7:0];
                CFG_STALL_THRESHOLD: r_thresh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_fail      <= '0;
            r_free      <= '1;
            r_tag_ok    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (w_grant) begin
                r_free[w_grant_idx]   <= (w_grant_cnt == 8'd0);
                r_tag_ok[w_grant_idx] <= 1'b1;
                r_fail                <= '0;
            end
            if (w_fail) begin
                r_fail <= w_stall_hit ? 16'd0 : w_fail_inc[15:0];
            end
            if ((w_rel_wr && (w_rel_cnt == 8'd0)) || w_cancel) begin
                r_free[w_idx_r] <= 1'b1;
            end
            if ((r_st == S_DONE) && !w_out_busy) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind     <= i_kind;
            r_dest     <= i_dest;
            r_prio     <= ((i_dest != r_host) && i_is_system) || i_is_anti;
            r_idx      <= i_buffer_index;
            r_in_range <= (32'(i_buffer_index) < NUM_BUFFERS);
        end
        if (w_scan_start) begin
            r_tag0      <= w_tag_val;
            r_scan_addr <= IW'(1);
        end else if (w_scan_next) begin
            r_scan_addr <= r_scan_addr + IW'(1);
        end
        if (w_finish) begin
            r_res_status <= w_res_status;
            r_res_idx    <= w_res_idx;
            r_res_cnt    <= w_res_cnt;
            r_res_prio   <= w_res_prio;
            r_res_stall  <= w_res_stall;
        end
        if ((r_st == S_DONE) && !w_out_busy) begin
            r_out_status <= r_res_status;
            r_out_idx    <= r_res_idx;
            r_out_cnt    <= r_res_cnt;
            r_out_prio   <= r_res_prio;
            r_out_stall  <= r_res_stall;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_granted_index = r_out_idx;
    assign o_count_after   = r_out_cnt;
    assign o_is_priority   = r_out_prio;
    assign o_stall_flag    = r_out_stall;

    // A grant always lands on a buffer that was free.
    `PSBA_ASSERT_IMPLY(a_grant_free, i_clk, i_rst_n, w_grant, r_free[w_grant_idx])
    // The tag walk never leaves the low partition.
    `PSBA_ASSERT_IMPLY(a_scan_bound, i_clk, i_rst_n, r_st == S_SCAN, CW'(r_scan_addr) < w_split)
    // A stall flag only comes with a failed allocation.
    `PSBA_ASSERT_IMPLY(a_stall_fail, i_clk, i_rst_n, o_out_valid && o_stall_flag, o_status == STATUS_NO_BUFFER)
    // A finished result reaches the output register as the state machine leaves the done state for idle.
    `PSBA_ASSERT_NEXT(a_done_out, i_clk, i_rst_n, (r_st == S_DONE) && !w_out_busy, o_out_valid && (r_st == S_IDLE))

endmodule
